// ===== hdl/sorted_priority_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared assertion forms for the checker of the sorted priority queue.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_priority_queue: next-cycle check failed");

`endif

// ===== hdl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, field layout, request and status codes, and the cell control type.
// ---------------------------------------------------------------------------
package spq_pkg;

   // Store geometry.
   localparam int CAPACITY    = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // Request layout: mode, then key.
   localparam int MODE_WIDTH    = 2;
   localparam int REQ_BITS      = MODE_WIDTH + KEY_WIDTH;
   localparam int REQ_DATA_BITS = ((REQ_BITS + 7) / 8) * 8;

   // Result layout: head key, count, empty flag, status.
   localparam int STATUS_WIDTH  = 2;
   localparam int RSP_COUNT_LSB = KEY_WIDTH;
   localparam int RSP_EMPTY_BIT = KEY_WIDTH + COUNT_WIDTH;
   localparam int RSP_STAT_LSB  = RSP_EMPTY_BIT + 1;
   localparam int RSP_BITS      = RSP_STAT_LSB + STATUS_WIDTH;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_QUERY = 2'd0,
      MODE_PUSH  = 2'd1,
      MODE_POP   = 2'd2
   } spq_mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // Broadcast control shared by every cell of the row.
   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [KEY_WIDTH-1:0] key;
   } spq_ctrl_type;

endpackage

// ===== hdl/spq_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key of the sorted row and trades keys with its two neighbors.
// ---------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic                 clock,
   input  spq_ctrl_type         ctrl,
   input  logic                 occupied,   // this slot holds a stored key
   input  logic                 is_tail,    // first free slot
   input  logic                 left_lt,    // new key is below the left key
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic [KEY_WIDTH-1:0] right_key,
   output logic                 lt,
   output logic [KEY_WIDTH-1:0] key,
   output logic [KEY_WIDTH-1:0] key_next
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // The new key sorts strictly before the key held here.
   assign lt = occupied && ($signed(ctrl.key) < $signed(key_ff));

   // On a push, cells after the insertion point take their left neighbor's
   // key, the insertion point takes the new key; a pop shifts toward the head.
   always_comb begin
      key_in = key_ff;
      if (ctrl.push) begin
         if (left_lt) begin
            key_in = left_key;
         end else if (lt || is_tail) begin
            key_in = ctrl.key;
         end
      end else if (ctrl.pop) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key      = key_ff;
   assign key_next = key_in;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of signed keys kept in ascending order in a row of cells.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  req_     | in        | tdata: mode, key
//  rsp_     | out       | tdata: head_key, count, is_empty, status
//
//  Every cell compares the new key with its own and shifts in parallel, so a
//  transfer can be accepted every cycle while the result stream is not stalled.
//  The result is held in an output register; a new request is accepted
//  whenever that register is empty or is being drained in the same cycle.
//  Reset clears the key count and the result valid flag; cell contents are
//  only read below the count and need no reset.
// ---------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // mode[1:0], key[33:2]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // head_key, count, is_empty, status
);

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(CAPACITY);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]    rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [MODE_WIDTH-1:0]  req_mode;
   logic [KEY_WIDTH-1:0]   req_key;
   logic                   is_full, is_none;
   spq_status_type         status;
   spq_ctrl_type           ctrl;

   logic [CAPACITY-1:0]    cell_lt;
   logic [CAPACITY-1:0]    cell_occupied;
   logic [CAPACITY-1:0]    cell_tail;
   logic [KEY_WIDTH-1:0]   cell_key  [CAPACITY];
   logic [KEY_WIDTH-1:0]   cell_next [CAPACITY];
   logic [KEY_WIDTH-1:0]   head_key;

   assign req_mode = req_tdata[MODE_WIDTH-1:0];
   assign req_key  = req_tdata[REQ_BITS-1:MODE_WIDTH];

   // Output register is free or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_full = (count_ff == FULL_COUNT);
   assign is_none = (count_ff == '0);

   // Decode the request and guard full pushes and empty pops.
   always_comb begin
      ctrl.push = 1'b0;
      ctrl.pop  = 1'b0;
      ctrl.key  = req_key;
      status    = STATUS_OK;
      count_in  = count_ff;
      case (req_mode)
         MODE_PUSH: begin
            if (is_full) begin
               status = STATUS_FULL;
            end else begin
               ctrl.push = accept;
               if (accept) count_in = count_ff + 1'b1;
            end
         end
         MODE_POP: begin
            if (is_none) begin
               status = STATUS_EMPTY;
            end else begin
               ctrl.pop = accept;
               if (accept) count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   // Row of cells; slot 0 holds the head.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [COUNT_WIDTH-1:0] SLOT = COUNT_WIDTH'(i);

      assign cell_occupied[i] = (SLOT < count_ff);
      assign cell_tail[i]     = (SLOT == count_ff);

      spq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (cell_occupied[i]),
         .is_tail   (cell_tail[i]),
         .left_lt   ((i == 0) ? 1'b0 : cell_lt[(i == 0) ? 0 : i - 1]),
         .left_key  (cell_key[(i == 0) ? 0 : i - 1]),
         .right_key (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
         .lt        (cell_lt[i]),
         .key       (cell_key[i]),
         .key_next  (cell_next[i])
      );
   end

   // Result after the request takes effect.
   assign head_key = (count_in == '0) ? '0 : cell_next[0];

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_data_in  = {status, (count_in == '0), count_in, head_key};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);

endmodule

// ===== hdl/spq_checker.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_checker
   import spq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [COUNT_WIDTH-1:0]  rsp_count;
   logic                    rsp_empty;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [KEY_WIDTH-1:0]    rsp_head;

   assign rsp_head   = rsp_tdata[KEY_WIDTH-1:0];
   assign rsp_count  = rsp_tdata[RSP_EMPTY_BIT-1:RSP_COUNT_LSB];
   assign rsp_empty  = rsp_tdata[RSP_EMPTY_BIT];
   assign rsp_status = rsp_tdata[RSP_BITS-1:RSP_STAT_LSB];

   // The empty flag agrees with the count.
   `SPQ_ASSERT_NOW(a_empty_flag, clock, reset, rsp_tvalid, rsp_empty == (rsp_count == '0))

   // An empty queue reports a zero head.
   `SPQ_ASSERT_NOW(a_empty_head, clock, reset, rsp_tvalid && rsp_empty, rsp_head == '0)

   // A refused push reports a full queue.
   `SPQ_ASSERT_NOW(a_full_status, clock, reset, rsp_tvalid && (rsp_status == STATUS_FULL), rsp_count == COUNT_WIDTH'(CAPACITY))

   // A refused pop reports an empty queue.
   `SPQ_ASSERT_NOW(a_pop_status, clock, reset, rsp_tvalid && (rsp_status == STATUS_EMPTY), rsp_empty)

   // A stalled result holds until the transfer.
   `SPQ_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
